@@ src/uss_pkg.sv @@
`default_nettype none
package uss_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int DEF_CAPACITY = 128;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ src/uss_ifs.sv @@
`default_nettype none
interface uss_req_if;
    logic                            valid;
    logic                            ready;
    uss_pkg::t_op                    opcode;
    logic signed [uss_pkg::DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface uss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    uss_pkg::t_status             status;
    logic [uss_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output found, output status, output count, input ready);
    modport sink   (input valid, input found, input status, input count, output ready);
endinterface
`default_nettype wire

@@ src/uss_cell.sv @@
`default_nettype none
module uss_cell #(
    parameter int CAPACITY = uss_pkg::DEF_CAPACITY,
    parameter int IDX      = 0,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire                          i_clk,
    input  uss_pkg::t_cell_ctl           i_ctl,
    input  wire [uss_pkg::DATA_W-1:0]    i_value,
    input  wire [CW-1:0]                 i_count,
    input  wire [IW-1:0]                 i_slot,
    input  wire [uss_pkg::DATA_W-1:0]    i_next,
    output logic [uss_pkg::DATA_W-1:0]   o_elem,
    output logic                         o_hit
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);

    logic [uss_pkg::DATA_W-1:0] r_elem;
    logic                       r_hit;

    // A slot at or above the fill count holds nothing and never matches.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= (r_elem == i_value) && (IDX_C < i_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (IDX_C == i_count)) begin
            r_elem <= i_value;
        end else if (i_ctl.del && (IDX_I >= i_slot)) begin
            r_elem <= i_next;
        end
    end

    assign o_elem = r_elem;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire

@@ src/unordered_set_store.sv @@
// Bounded set of distinct 32-bit values held in a row of cells, packed in
// insertion order.
// Request channel i_req: opcode (insert, delete, lookup, clear) and value.
// Response channel o_rsp: found, status and the count after the operation.
// Every request yields exactly one response.
// For each item, at the transfer edge every cell compares its entry against
// the value; in the following cycle the match is encoded and the cells
// append or shift down by one place, and the response is registered. The
// response is visible on the cycle after that. No new request is taken
// until the single compare-then-update pass of the cell row for the last
// item is done.
// Reset empties the set at once; entries are not cleared, only the count.
// If the receiver stalls, the response waits in the output register and no
// new request is taken until it has been transferred (a request may be
// taken on the very cycle that the response leaves).
`default_nettype none
module unordered_set_store #(
    parameter int CAPACITY = uss_pkg::DEF_CAPACITY
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    uss_req_if.sink   i_req,
    uss_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    uss_pkg::t_op               r_op;
    logic [uss_pkg::DATA_W-1:0] r_val;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_out_valid;
    logic                       r_found;
    uss_pkg::t_status           r_status, n_status;

    logic                       w_accept;
    logic                       w_found;
    logic [IW-1:0]              w_slot;
    logic [CAPACITY-1:0]        w_hit;
    logic [uss_pkg::DATA_W-1:0] w_elem [CAPACITY];
    logic [uss_pkg::DATA_W-1:0] w_cell_val;
    uss_pkg::t_cell_ctl         w_ctl;
    logic [CW+uss_pkg::COUNT_W-1:0] w_count_ext;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // The compare runs on the request value at the transfer edge.
    assign w_cell_val = w_accept ? i_req.value : r_val;

    assign w_found = |w_hit;

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_hit[i]) begin
                w_slot = w_slot | IW'(i);
            end
        end
    end

    always_comb begin
        w_ctl     = '0;
        w_ctl.cmp = w_accept;
        if (r_state == S_EXEC) begin
            w_ctl.ins = (r_op == uss_pkg::OP_INSERT) && !w_found && (r_count < CAP_C);
            w_ctl.del = (r_op == uss_pkg::OP_DELETE) && w_found;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = uss_pkg::ST_OK;
        unique case (r_op)
            uss_pkg::OP_INSERT: begin
                if (!w_found) begin
                    if (r_count >= CAP_C) begin
                        n_status = uss_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            uss_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    n_status = uss_pkg::ST_EMPTY;
                end else if (!w_found) begin
                    n_status = uss_pkg::ST_NOT_FOUND;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            uss_pkg::OP_LOOKUP: begin
                if (r_count == '0) begin
                    n_status = uss_pkg::ST_EMPTY;
                end else if (!w_found) begin
                    n_status = uss_pkg::ST_NOT_FOUND;
                end
            end
            uss_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.opcode;
            r_val <= i_req.value;
        end
        if (r_state == S_EXEC) begin
            r_found  <= w_found && (r_op != uss_pkg::OP_CLEAR);
            r_status <= n_status;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [uss_pkg::DATA_W-1:0] w_next;
            if (g == CAPACITY - 1) begin : g_last
                assign w_next = w_elem[g];
            end else begin : g_mid
                assign w_next = w_elem[g+1];
            end
            uss_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g),
                .CW       (CW),
                .IW       (IW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_value (w_cell_val),
                .i_count (r_count),
                .i_slot  (w_slot),
                .i_next  (w_next),
                .o_elem  (w_elem[g]),
                .o_hit   (w_hit[g])
            );
        end
    endgenerate

    assign w_count_ext  = {{uss_pkg::COUNT_W{1'b0}}, r_count};
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.found  = r_found;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = w_count_ext[uss_pkg::COUNT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_out_valid && r_state == S_IDLE))
        else $error("operation finished without a response");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_status == uss_pkg::ST_OK))
        else $error("found with a failing status");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(w_hit))
        else $error("value held in more than one slot");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !w_accept)
        else $error("request taken while a response is stalled");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uss_pkg::*;

    localparam int SET_CAP      = DEF_CAPACITY;
    localparam int POOL_N       = 192;
    localparam int RANDOM_ITEMS = 1530;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic               found;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } set_result_t;

    typedef struct {
        t_op               op;
        logic [DATA_W-1:0] value;
        bit                typed;
        set_result_t       res;
    } stim_row_t;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_FILL} mix_kind_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uss_req_if req_if();
    uss_rsp_if rsp_if();

    unordered_set_store #(.CAPACITY(SET_CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the set, packed in insertion order.
    logic [DATA_W-1:0] held[SET_CAP];
    int                held_n = 0;

    logic [DATA_W-1:0] value_pool[POOL_N];
    set_result_t       pending_q[$];
    stim_row_t         directed_q[$];
    int                mismatches = 0;
    int                cycle_cnt = 0;
    bit                calm = 1'b0;

    function automatic set_result_t apply_op(input t_op op, input logic [DATA_W-1:0] v);
        set_result_t r;
        int          slot;
        int          i;
        r.found  = 1'b0;
        r.status = ST_OK;
        slot     = held_n;
        for (i = held_n - 1; i >= 0; i--) begin
            if (held[i] == v) slot = i;
        end
        case (op)
            OP_INSERT: begin
                if (slot < held_n) begin
                    r.found = 1'b1;
                end else if (held_n >= SET_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    held[held_n] = v;
                    held_n++;
                end
            end
            OP_DELETE: begin
                if (held_n == 0) begin
                    r.status = ST_EMPTY;
                end else if (slot < held_n) begin
                    r.found = 1'b1;
                    for (i = slot; i < held_n - 1; i++) held[i] = held[i + 1];
                    held_n--;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_LOOKUP: begin
                if (held_n == 0) r.status = ST_EMPTY;
                else if (slot < held_n) r.found = 1'b1;
                else r.status = ST_NOT_FOUND;
            end
            default: held_n = 0;
        endcase
        r.count = COUNT_W'(held_n);
        return r;
    endfunction

    // Mostly no gap, now and then a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input int held_pct, input int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < held_pct && held_n > 0) return held[$urandom_range(0, held_n - 1)];
        if (r < held_pct + pool_pct) return value_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom();
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_row(input t_op op, input logic [DATA_W-1:0] v, input bit typed,
                           input logic found, input t_status status, input int count);
        stim_row_t row;
        row.op     = op;
        row.value  = v;
        row.typed  = typed;
        row.res    = '{found, status, COUNT_W'(count)};
        directed_q.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Valid is left high so that the next item can follow with no gap.
    task automatic send_op(input t_op op, input logic [DATA_W-1:0] v, input bit typed,
                           input set_result_t typed_res);
        set_result_t predicted;
        int          gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid  <= 1'b0;
            req_if.opcode <= t_op'($urandom_range(0, 3));
            req_if.value  <= $urandom();
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.value  <= v;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        predicted = apply_op(op, v);
        pending_q.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // The request is withdrawn first, so that nothing is taken twice while waiting.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(input mix_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            MIX_GROW:   r = (r < 70) ? 0 : (r < 80) ? 1 : (r < 99) ? 2 : 3;
            MIX_SHRINK: r = (r < 15) ? 0 : (r < 75) ? 1 : (r < 99) ? 2 : 3;
            default:    r = (r < 35) ? 0 : (r < 65) ? 1 : (r < 98) ? 2 : 3;
        endcase
        case (t_op'(r))
            OP_INSERT: send_op(OP_INSERT, pick_value(25, 55), 1'b0, '0);
            OP_DELETE: send_op(OP_DELETE, pick_value(55, 25), 1'b0, '0);
            OP_LOOKUP: send_op(OP_LOOKUP, pick_value(55, 25), 1'b0, '0);
            default:   send_op(OP_CLEAR, $urandom(), 1'b0, '0);
        endcase
    endtask

    // Response side: ready held high for a while, then stalled.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (pick_gap() > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        set_result_t want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_q.size() == 0) begin
                report_mismatch("response transfer with no request outstanding");
            end else begin
                want = pending_q.pop_front();
                if (rsp_if.found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              rsp_if.found, want.found));
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              rsp_if.count, want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int        sent;
        int        phase_len;
        int        extra;
        mix_kind_t kind;

        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.opcode <= OP_INSERT;
        req_if.value  <= '0;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h0000_0001;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        value_pool[4] = 32'h7FFF_FFFF;
        value_pool[5] = 32'h5555_5555;
        value_pool[6] = 32'hAAAA_AAAA;
        value_pool[7] = 32'h0000_0080;
        for (int i = 8; i < POOL_N; i++)
            value_pool[i] = (i % 2) ? $urandom() : DATA_W'($urandom_range(0, 300));

        add_row(OP_LOOKUP, 32'h0000_0000, 1, 1'b0, ST_EMPTY,     0);
        add_row(OP_DELETE, 32'h0000_0000, 1, 1'b0, ST_EMPTY,     0);
        add_row(OP_INSERT, 32'h8000_0000, 1, 1'b0, ST_OK,        1);
        add_row(OP_INSERT, 32'h7FFF_FFFF, 1, 1'b0, ST_OK,        2);
        add_row(OP_INSERT, 32'h0000_0000, 1, 1'b0, ST_OK,        3);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 1, 1'b0, ST_OK,        4);
        add_row(OP_INSERT, 32'h8000_0000, 1, 1'b1, ST_OK,        4);
        add_row(OP_LOOKUP, 32'h7FFF_FFFF, 1, 1'b1, ST_OK,        4);
        add_row(OP_LOOKUP, 32'h0000_0001, 1, 1'b0, ST_NOT_FOUND, 4);
        add_row(OP_DELETE, 32'h0000_0005, 1, 1'b0, ST_NOT_FOUND, 4);
        // Removing the first slot makes every later entry shift down.
        add_row(OP_DELETE, 32'h8000_0000, 1, 1'b1, ST_OK,        3);
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 0, 1'b0, ST_OK,        0);
        add_row(OP_LOOKUP, 32'h8000_0000, 0, 1'b0, ST_OK,        0);
        add_row(OP_DELETE, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        2);
        add_row(OP_INSERT, 32'h8000_0000, 0, 1'b0, ST_OK,        0);
        add_row(OP_LOOKUP, 32'h0000_0000, 0, 1'b0, ST_OK,        0);
        add_row(OP_CLEAR,  32'hDEAD_BEEF, 1, 1'b0, ST_OK,        0);
        add_row(OP_LOOKUP, 32'h0000_0000, 1, 1'b0, ST_EMPTY,     0);
        add_row(OP_CLEAR,  32'hFFFF_FFFF, 1, 1'b0, ST_OK,        0);
        add_row(OP_INSERT, 32'h5555_5555, 1, 1'b0, ST_OK,        1);
        add_row(OP_DELETE, 32'h5555_5555, 1, 1'b1, ST_OK,        0);
        add_row(OP_INSERT, 32'hAAAA_AAAA, 1, 1'b0, ST_OK,        1);
        add_row(OP_DELETE, 32'h5555_5555, 0, 1'b0, ST_OK,        0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        foreach (directed_q[i])
            send_op(directed_q[i].op, directed_q[i].value, directed_q[i].typed,
                    directed_q[i].res);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = mix_kind_t'($urandom_range(0, 5) % 4);
            calm = ($urandom_range(0, 4) == 0);
            if (kind == MIX_FILL) begin
                // Fill with fresh values, then push against the full set,
                // including a duplicate, which is reported as held.
                while (held_n < SET_CAP) begin
                    send_op(OP_INSERT, $urandom(), 1'b0, '0);
                    sent++;
                end
                for (extra = 0; extra < 3; extra++) begin
                    send_op(OP_INSERT, $urandom(), 1'b0, '0);
                    send_op(OP_LOOKUP, pick_value(50, 20), 1'b0, '0);
                end
                send_op(OP_INSERT, held[$urandom_range(0, SET_CAP - 1)], 1'b0, '0);
                sent += 7;
            end else begin
                phase_len = $urandom_range(40, 150);
                repeat (phase_len) send_random(kind);
                sent += phase_len;
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        calm = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
